@@ hdl/fq12_pkg.sv @@
`default_nettype none
package fq12_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int NUM_COEFS  = 7;
  localparam int Q_SHIFT    = 12;
  localparam int ACC_W      = SAMPLE_W + Q_SHIFT;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int TAPCNT_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int COEF_SEL_W = $clog2(NUM_COEFS);

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = CFG_IDX_W'(NUM_COEFS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [TAPCNT_W-1:0]                tap_count;
    logic [NUM_COEFS-1:0][COEF_W-1:0]   coef;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/fq12_regs.sv @@
`default_nettype none
module fq12_regs
  import fq12_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [COEF_SEL_W-1:0] coef_sel;
  logic [CFG_IDX_W-1:0]  coef_off;

  assign cfg_ready = 1'b1;
  assign coef_off  = cfg_index - REG_COEF_FIRST;
  assign coef_sel  = coef_off[COEF_SEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TAP_COUNT) begin
        cfg.tap_count <= cfg_data[TAPCNT_W-1:0];
      end else if (cfg_index inside {[REG_COEF_FIRST:REG_COEF_LAST]}) begin
        cfg.coef[coef_sel] <= cfg_data[COEF_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/fq12_taps.sv @@
`default_nettype none
module fq12_taps
  import fq12_pkg::*;
#(
  parameter int MAX_TAPS = 7
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [SAMPLE_W-1:0]                sample,
  input  wire logic                               frame_start,
  output logic                                    win_valid,
  input  wire logic                               win_ready,
  output logic [MAX_TAPS-1:0][SAMPLE_W-1:0]       win
);

  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] win_next;

  assign in_ready = !win_valid || win_ready;

  // newest sample in lane 0, older samples cleared at frame start
  always_comb begin
    win_next[0] = sample;
    for (int j = 1; j < MAX_TAPS; j++) begin
      win_next[j] = frame_start ? '0 : win[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      win       <= '0;
    end else if (in_valid && in_ready) begin
      win_valid <= 1'b1;
      win       <= win_next;
    end else if (win_ready) begin
      win_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hdl/fq12_mac.sv @@
`default_nettype none
module fq12_mac
  import fq12_pkg::*;
#(
  parameter int MAX_TAPS = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfg_t                          cfg,
  input  wire logic                          win_valid,
  output logic                               win_ready,
  input  wire logic [MAX_TAPS-1:0][SAMPLE_W-1:0] win,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [SAMPLE_W-1:0]                filtered
);

  logic                             prod_valid;
  logic                             prod_ready;
  logic [MAX_TAPS-1:0][ACC_W-1:0]   prod;
  logic [MAX_TAPS-1:0][ACC_W-1:0]   prod_next;
  logic [TAPCNT_W-1:0]              taps_eff;
  logic [ACC_W-1:0]                 acc;

  assign taps_eff = (cfg.tap_count > TAPCNT_W'(MAX_TAPS)) ? TAPCNT_W'(MAX_TAPS)
                                                           : cfg.tap_count;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_lane
    logic signed [PROD_W-1:0] full;
    assign full = $signed(cfg.coef[j]) * $signed(win[j]);
    assign prod_next[j] = (TAPCNT_W'(j) < taps_eff) ? full[ACC_W-1:0] : '0;
  end

  // only the low bits of the sum reach the output, so wrapping is exact
  always_comb begin
    acc = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      acc = acc + prod[j];
    end
  end

  assign prod_ready = !out_valid || out_ready;
  assign win_ready  = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (win_valid && win_ready) begin
      prod_valid <= 1'b1;
    end else if (prod_ready) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid && win_ready) begin
      prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_valid && prod_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      filtered <= acc[ACC_W-1:Q_SHIFT];
    end
  end

endmodule
`default_nettype wire

@@ hdl/fir_filter_q12.sv @@
// fir_filter_q12: seven-lane q12 fir filter, one multiplier per tap lane
// an accepted item passes the sample window, product and sum registers in turn
// throughput: one item per cycle while out_ready is high (sample window, product and sum registers)
// reset: clears tap count, coefficients, sample history and all valid flags
// reset needs no clearing pass; the block accepts items the cycle after reset
`default_nettype none
module fir_filter_q12
  import fq12_pkg::*;
#(
  parameter int MAX_TAPS = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic                  frame_start,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SAMPLE_W-1:0]        filtered,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                              cfg;
  logic                              win_valid;
  logic                              win_ready;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] win;

  fq12_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fq12_taps #(.MAX_TAPS(MAX_TAPS)) u_taps (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .frame_start (frame_start),
    .win_valid   (win_valid),
    .win_ready   (win_ready),
    .win         (win)
  );

  fq12_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered)
  );

  a_accept_fills_window: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> win_valid && (win[0] == $past(sample)))
    else $error("accepted item did not enter the sample window");

  a_window_holds: assert property (@(posedge clk) disable iff (rst)
    win_valid && !win_ready |=> win_valid && $stable(win))
    else $error("sample window changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !win_valid)
    else $error("valid flags not cleared by reset");

endmodule
`default_nettype wire
